@@ rtl/core/marked_element_array_with_linked_list_top_assert.svh @@
// Assertion macros used by the port-level checker of the marked element array.
// Each macro expands to one labeled concurrent assertion on the rising edge
// of the given clock, disabled while the active-low reset is asserted.
`ifndef MARKED_ELEMENT_ARRAY_WITH_LINKED_LIST_TOP_ASSERT_SVH
`define MARKED_ELEMENT_ARRAY_WITH_LINKED_LIST_TOP_ASSERT_SVH

// Same-cycle implication: cond holds, so does expect_true.
`define MEAL_ASSERT_IMPLY(label, clk, rst_n, cond, expect_true) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_true)) else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cond holds, so does expect_true in the next cycle.
`define MEAL_ASSERT_NEXT(label, clk, rst_n, cond, expect_true) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_true)) else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/meal_pkg.sv @@
// ----------------------------------------------------------------------------
// meal_pkg
// Shared constants and controller/datapath interface types of the marked
// element array with an intrusive doubly linked list.
// ----------------------------------------------------------------------------
package meal_pkg;

    localparam int ENTRIES = 256;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int IDX_W   = 9;
    localparam int VAL_W   = 32;

    // Link value that names the sentinel slot (list head/tail anchor)
    localparam logic [IDX_W-1:0] SENTINEL  = IDX_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LEN_RESET = 9'd256;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // take the input word and fetch the element
        logic update;   // store value, start append or do unlink
        logic link;     // finish append at the list tail
        logic load;     // load the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic append;   // current write appends a new element to the list
        logic out_free; // output register can take a word this cycle
    } status_t;

endpackage

@@ rtl/core/meal_dp.sv @@
// ----------------------------------------------------------------------------
// meal_dp
// Datapath: element memory with per-entry valid bits, link memories,
// sentinel head/tail, mark count, length register and output register.
// ----------------------------------------------------------------------------
module meal_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  meal_pkg::cmd_t                    cmd,
    output meal_pkg::status_t                 status,
    input  logic                              cfg_we,
    input  logic [meal_pkg::IDX_W-1:0]        cfg_wdata,
    input  logic                              opcode,
    input  logic [meal_pkg::IDX_W-1:0]        index,
    input  logic signed [meal_pkg::VAL_W-1:0] write_value,
    input  logic                              value_marked,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [meal_pkg::VAL_W-1:0] read_value,
    output logic                              index_valid,
    output logic [meal_pkg::IDX_W-1:0]        marked_count,
    output logic [meal_pkg::IDX_W-1:0]        first_marked,
    output logic                              any_marked
);

    localparam int ADDR_W = meal_pkg::ADDR_W;
    localparam int IDX_W  = meal_pkg::IDX_W;
    localparam int VAL_W  = meal_pkg::VAL_W;
    localparam int ENTRIES = meal_pkg::ENTRIES;

    // Memories: {mark, value}, next links, prev links
    logic [VAL_W:0]     elem_mem [ENTRIES];
    logic [IDX_W-1:0]   next_mem [ENTRIES];
    logic [IDX_W-1:0]   prev_mem [ENTRIES];
    logic [ENTRIES-1:0] ent_valid_reg;

    // Captured item
    logic               op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VAL_W-1:0]   wval_reg;
    logic               mk_reg;
    logic               inrange_reg;

    // Fetched element
    logic [VAL_W:0]     elem_q_reg;
    logic               ent_valid_q_reg;
    logic [IDX_W-1:0]   next_q_reg;
    logic [IDX_W-1:0]   prev_q_reg;

    // List anchors and count
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   len_reg;

    // Output register
    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_rval_reg;
    logic               out_ivalid_reg;
    logic [IDX_W-1:0]   out_count_reg;
    logic [IDX_W-1:0]   out_first_reg;
    logic               out_any_reg;

    logic [IDX_W-1:0]   len_eff;
    logic [ADDR_W-1:0]  addr;
    logic               old_mark;
    logic [VAL_W-1:0]   old_value;
    logic               do_write;
    logic               do_append;
    logic               do_unlink;
    logic               nx_we, pv_we;
    logic [ADDR_W-1:0]  nx_waddr, pv_waddr;
    logic [IDX_W-1:0]   nx_wdata, pv_wdata;
    logic [VAL_W-1:0]   rval;

    assign len_eff   = (len_reg > meal_pkg::SENTINEL) ? meal_pkg::SENTINEL : len_reg;
    assign addr      = idx_reg[ADDR_W-1:0];
    assign old_mark  = ent_valid_q_reg & elem_q_reg[VAL_W];
    assign old_value = ent_valid_q_reg ? elem_q_reg[VAL_W-1:0] : '0;
    assign do_write  = (op_reg == meal_pkg::OP_WRITE) && inrange_reg;
    assign do_append = do_write && mk_reg && !old_mark;
    assign do_unlink = do_write && !mk_reg && old_mark;

    assign status.append   = do_append;
    assign status.out_free = !out_valid_reg || !out_stall;

    // Capture the word and fetch element and links
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg          <= opcode;
            idx_reg         <= index;
            wval_reg        <= write_value;
            mk_reg          <= value_marked;
            inrange_reg     <= index < len_eff;
            elem_q_reg      <= elem_mem[index[ADDR_W-1:0]];
            ent_valid_q_reg <= ent_valid_reg[index[ADDR_W-1:0]];
            next_q_reg      <= next_mem[index[ADDR_W-1:0]];
            prev_q_reg      <= prev_mem[index[ADDR_W-1:0]];
        end
    end

    // Element store
    always_ff @(posedge clk)
    begin
        if (cmd.update && do_write)
        begin
            elem_mem[addr] <= {mk_reg, wval_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
        end
        else if (cmd.update && do_write)
        begin
            ent_valid_reg[addr] <= 1'b1;
        end
    end

    // Link write ports: one write per memory per cycle
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = addr;
        nx_wdata = meal_pkg::SENTINEL;
        pv_we    = 1'b0;
        pv_waddr = addr;
        pv_wdata = tail_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.update && do_append)
        begin
            nx_we      = 1'b1;
            pv_we      = 1'b1;
            count_next = count_reg + 9'd1;
        end
        else if (cmd.update && do_unlink)
        begin
            count_next = count_reg - 9'd1;
            if (prev_q_reg == meal_pkg::SENTINEL)
            begin
                head_next = next_q_reg;
            end
            else
            begin
                nx_we    = 1'b1;
                nx_waddr = prev_q_reg[ADDR_W-1:0];
                nx_wdata = next_q_reg;
            end
            if (next_q_reg == meal_pkg::SENTINEL)
            begin
                tail_next = prev_q_reg;
            end
            else
            begin
                pv_we    = 1'b1;
                pv_waddr = next_q_reg[ADDR_W-1:0];
                pv_wdata = prev_q_reg;
            end
        end
        else if (cmd.link)
        begin
            tail_next = idx_reg;
            if (tail_reg == meal_pkg::SENTINEL)
            begin
                head_next = idx_reg;
            end
            else
            begin
                nx_we    = 1'b1;
                nx_waddr = tail_reg[ADDR_W-1:0];
                nx_wdata = idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= meal_pkg::SENTINEL;
            tail_reg  <= meal_pkg::SENTINEL;
            count_reg <= '0;
            len_reg   <= meal_pkg::LEN_RESET;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

    // Output register
    always_comb
    begin
        if (op_reg == meal_pkg::OP_WRITE)
        begin
            rval = '0;
        end
        else if (inrange_reg)
        begin
            rval = old_value;
        end
        else
        begin
            rval = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_rval_reg   <= rval;
            out_ivalid_reg <= inrange_reg;
            out_count_reg  <= count_reg;
            out_first_reg  <= (head_reg == meal_pkg::SENTINEL) ? len_eff : head_reg;
            out_any_reg    <= count_reg != '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = out_rval_reg;
    assign index_valid  = out_ivalid_reg;
    assign marked_count = out_count_reg;
    assign first_marked = out_first_reg;
    assign any_marked   = out_any_reg;

endmodule

@@ rtl/core/meal_ctrl.sv @@
// ----------------------------------------------------------------------------
// meal_ctrl
// Controller: sequences capture, update, tail link and output load per word.
// ----------------------------------------------------------------------------
module meal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  meal_pkg::status_t status,
    output meal_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_LINK   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.append ? ST_LINK : ST_DONE;
            end
            ST_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/marked_element_array_with_linked_list_top.sv @@
// ----------------------------------------------------------------------------
// marked_element_array_with_linked_list_top
// Array of signed values with a mark per element; marked elements are kept
// in marking order in a doubly linked list anchored at a sentinel slot.
// ----------------------------------------------------------------------------
//
//  channel   handshake             fields
//  -------   -------------------   ----------------------------------------
//  in        in_valid / in_stall   opcode, index, write_value, value_marked
//  out       out_valid / out_stall read_value, index_valid, marked_count,
//                                  first_marked, any_marked
//  cfg       cfg_we                cfg_wdata (array_length)
//
//  A word is captured with its element and links fetched, then updated,
//  then linked at the list tail when a write marks a new element (the link
//  memories have one write port each, and an append writes the next link
//  twice: new tail, old tail), then loaded into the output register.
//  One word is in work at a time; the output register holds a finished
//  word while the next one is accepted and processed.
//  Reset clears the per-entry valid bits at once; an entry never written
//  reads as zero and unmarked, so no clearing pass is needed.
//  A stalled output holds its word; the controller waits in its last
//  state until the output register frees up.
//
module marked_element_array_with_linked_list_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [meal_pkg::IDX_W-1:0]        cfg_wdata,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [meal_pkg::IDX_W-1:0]        index,
    input  logic signed [meal_pkg::VAL_W-1:0] write_value,
    input  logic                              value_marked,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [meal_pkg::VAL_W-1:0] read_value,
    output logic                              index_valid,
    output logic [meal_pkg::IDX_W-1:0]        marked_count,
    output logic [meal_pkg::IDX_W-1:0]        first_marked,
    output logic                              any_marked
);

    meal_pkg::cmd_t    cmd;
    meal_pkg::status_t status;

    // Sequence each word: capture/fetch, update, optional tail link, load
    meal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Element and link memories, list anchors, count and output register
    meal_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .opcode       (opcode),
        .index        (index),
        .write_value  (write_value),
        .value_marked (value_marked),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .index_valid  (index_valid),
        .marked_count (marked_count),
        .first_marked (first_marked),
        .any_marked   (any_marked)
    );

endmodule

@@ rtl/core/meal_chk.sv @@
// ----------------------------------------------------------------------------
// meal_chk
// Port-level checker for the marked element array, bound to the top level.
// ----------------------------------------------------------------------------
`include "marked_element_array_with_linked_list_top_assert.svh"

module meal_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [meal_pkg::VAL_W-1:0] read_value,
    input logic                              index_valid,
    input logic [meal_pkg::IDX_W-1:0]        marked_count,
    input logic [meal_pkg::IDX_W-1:0]        first_marked,
    input logic                              any_marked
);

    // one word in work at a time
    `MEAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // any_marked agrees with the count
    `MEAL_ASSERT_IMPLY(a_any_matches_count, clk, rst_n, out_valid, any_marked == (marked_count != '0))

    // count never exceeds the element count
    `MEAL_ASSERT_IMPLY(a_count_bound, clk, rst_n, out_valid, marked_count <= meal_pkg::SENTINEL)

    // a stalled output word holds
    `MEAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_value) && $stable(index_valid) && $stable(marked_count) && $stable(first_marked))

endmodule

bind marked_element_array_with_linked_list_top meal_chk u_meal_chk (.*);
